// File: design/ocx_pkg.sv
// Shared constants, codes and types for the order crossover block.
package ocx_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int WEIGHT_BITS  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = 5;
  localparam int WFIELD_W     = 16;
  localparam int COST_W       = 21;
  localparam int VCOUNT_W     = 6;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(32);
  localparam logic [COST_W-1:0]   COST_MAX     = {COST_W{1'b1}};

  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_P1     = 2'd1;
  localparam logic [1:0] OP_LOAD_P2     = 2'd2;
  localparam logic [1:0] OP_START       = 2'd3;

  typedef struct packed {
    logic [1:0]          operation;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    column;
    logic [WFIELD_W-1:0] weight;
    logic [IDX_W-1:0]    position;
    logic [VTX_W-1:0]    vertex;
    logic [IDX_W-1:0]    cut_first;
    logic [IDX_W-1:0]    cut_second;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]  position;
    logic [VTX_W-1:0]  vertex;
    logic [COST_W-1:0] cost;
    logic              error;
    logic              last;
  } result_t;

  typedef struct packed {
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_row;
    logic [IDX_W-1:0]       wr_col;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   clear;
    logic                   lookup;
    logic [VTX_W-1:0]       a;
    logic [VTX_W-1:0]       b;
  } cost_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [COST_W-1:0] cost;
  } cost_stat_t;

endpackage

// File: design/ocx_cost.sv
// Weight memory and saturating tour-cost accumulator.
module ocx_cost (
  input  logic                  clk,
  input  logic                  rst,
  input  ocx_pkg::cost_cmd_t    cmd,
  output ocx_pkg::cost_stat_t   stat
);
  import ocx_pkg::*;

  logic [WEIGHT_BITS-1:0] wmem [MAX_VERTICES*MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] rdata;
  logic                   rd_in_range;
  logic                   lookup_d;
  logic [COST_W-1:0]      acc;
  logic [COST_W:0]        sum;

  // registered read, one lookup per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      wmem[{cmd.wr_row, cmd.wr_col}] <= cmd.wr_data;
    end
    rdata       <= wmem[{cmd.a[IDX_W-1:0], cmd.b[IDX_W-1:0]}];
    rd_in_range <= (int'(cmd.a) < MAX_VERTICES) && (int'(cmd.b) < MAX_VERTICES);
  end

  assign sum = {1'b0, acc} + (rd_in_range ? (COST_W+1)'(rdata) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_d <= 1'b0;
      acc      <= '0;
    end else begin
      lookup_d <= cmd.lookup;
      if (cmd.clear) begin
        acc <= '0;
      end else if (lookup_d) begin
        acc <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
      end
    end
  end

  assign stat.busy = lookup_d;
  assign stat.cost = acc;

endmodule

// File: design/ocx_seq.sv
// Crossover sequencer: parent tours, child tour, visited marks and pass control.
module ocx_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ocx_pkg::request_t             req,
  input  logic [ocx_pkg::CNT_W-1:0]     n,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ocx_pkg::result_t              res,
  output ocx_pkg::cost_cmd_t            cmd,
  input  ocx_pkg::cost_stat_t           stat
);
  import ocx_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COPY  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_COST  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [CNT_W-1:0]  idx;
  logic [IDX_W-1:0]  pc;
  logic [IDX_W-1:0]  pp;
  logic [CNT_W-1:0]  placed;
  logic [CNT_W-1:0]  free_slots;
  logic [VTX_W-1:0]  prev;
  logic [VTX_W-1:0]  first;

  logic [VTX_W-1:0]        p1    [MAX_VERTICES];
  logic [VTX_W-1:0]        p2    [MAX_VERTICES];
  logic [VTX_W-1:0]        child [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] filled;
  logic [MAX_VERTICES-1:0] visited;

  logic              accept;
  logic              is_start;
  logic              cut_bad;
  logic [CNT_W:0]    c1_x;
  logic [CNT_W:0]    c2_x;
  logic [IDX_W-1:0]  c_lo;
  logic [IDX_W-1:0]  c_hi;
  logic [IDX_W-1:0]  idx_i;
  logic [VTX_W-1:0]  child_rd;
  logic [VTX_W-1:0]  p2_v;
  logic              place;
  logic [IDX_W-1:0]  pc_inc;
  logic [IDX_W-1:0]  pp_inc;
  logic              idx_last;

  assign is_start = (req.operation == OP_START);
  assign c1_x     = (CNT_W+1)'(req.cut_first) + (CNT_W+1)'(2);
  assign c2_x     = (CNT_W+1)'(req.cut_second) + (CNT_W+1)'(2);
  // cut must lie in 1..n-2
  assign cut_bad  = (n < CNT_W'(3)) || (req.cut_first == '0) || (req.cut_second == '0) ||
                    (c1_x > {1'b0, n}) || (c2_x > {1'b0, n});
  assign c_lo     = (req.cut_first < req.cut_second) ? req.cut_first : req.cut_second;
  assign c_hi     = (req.cut_first < req.cut_second) ? req.cut_second : req.cut_first;

  assign in_ready = !rst && (state == S_IDLE) &&
                    (!(in_valid && is_start && cut_bad) || res_ready);
  assign accept   = in_valid && in_ready;

  assign idx_i    = idx[IDX_W-1:0];
  assign child_rd = filled[idx_i] ? child[idx_i] : '0;
  assign idx_last = (idx == n - CNT_W'(1));
  assign p2_v     = p2[pp];
  assign place    = !visited[p2_v[IDX_W-1:0]] && (placed < free_slots);
  assign pc_inc   = ({1'b0, pc} + CNT_W'(1) == n) ? '0 : pc + IDX_W'(1);
  assign pp_inc   = ({1'b0, pp} + CNT_W'(1) == n) ? '0 : pp + IDX_W'(1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      filled  <= '0;
      visited <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && is_start && !cut_bad) begin
            state   <= S_COPY;
            lo      <= c_lo;
            hi      <= c_hi;
            idx     <= CNT_W'(c_lo);
            filled  <= '0;
            visited <= '0;
          end
        end
        S_COPY: begin
          filled[idx_i]               <= 1'b1;
          visited[p1[idx_i][IDX_W-1:0]] <= 1'b1;
          if (idx_i == hi) begin
            state      <= S_FILL;
            pc         <= hi + IDX_W'(1);
            pp         <= hi + IDX_W'(1);
            placed     <= '0;
            idx        <= '0;
            free_slots <= n - (CNT_W'(hi) - CNT_W'(lo) + CNT_W'(1));
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_FILL: begin
          if (place) begin
            filled[pc] <= 1'b1;
            pc         <= pc_inc;
            placed     <= placed + CNT_W'(1);
          end
          pp <= pp_inc;
          if (idx_last) begin
            state <= S_COST;
            idx   <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_COST: begin
          // edge prev -> current; the closing edge wraps to the first vertex
          if (idx == '0) begin
            first <= child_rd;
          end
          prev <= child_rd;
          if (idx == n) begin
            state <= S_DRAIN;
            idx   <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!stat.busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // tour storage
  always_ff @(posedge clk) begin
    if (accept && (req.operation == OP_LOAD_P1)) begin
      p1[req.position] <= req.vertex;
    end
    if (accept && (req.operation == OP_LOAD_P2)) begin
      p2[req.position] <= req.vertex;
    end
    if (state == S_COPY) begin
      child[idx_i] <= p1[idx_i];
    end
    if ((state == S_FILL) && place) begin
      child[pc] <= p2_v;
    end
  end

  assign cmd.wr_en   = accept && (req.operation == OP_LOAD_WEIGHT);
  assign cmd.wr_row  = req.row;
  assign cmd.wr_col  = req.column;
  assign cmd.wr_data = req.weight[WEIGHT_BITS-1:0];
  assign cmd.clear   = accept && is_start && !cut_bad;
  assign cmd.lookup  = (state == S_COST) && (idx != '0);
  assign cmd.a       = prev;
  assign cmd.b       = (idx == n) ? first : child_rd;

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (state == S_EMIT) begin
      res_valid    = 1'b1;
      res.position = idx_i;
      res.vertex   = child_rd;
      res.cost     = idx_last ? stat.cost : '0;
      res.last     = idx_last;
    end else if ((state == S_IDLE) && in_valid && is_start && cut_bad) begin
      res_valid = 1'b1;
      res.error = 1'b1;
      res.last  = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> placed <= free_slots)
    else $error("fill placed more vertices than free positions");

  ap_fill_pc: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> {1'b0, pc} < n)
    else $error("fill position out of tour");

  ap_copy_range: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> (idx_i >= lo) && (idx_i <= hi))
    else $error("copy index outside segment");

  ap_emit_cost: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !stat.busy)
    else $error("emitting while cost still accumulating");

  ap_err_res: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> (state == S_IDLE) && res.last && !cmd.clear)
    else $error("error result outside idle");
`endif

endmodule

// File: design/order_crossover_with_tour_cost_top.sv
// Top level of the order crossover block with closed-tour cost.
// Load requests give no result.
// A rejected start gives its error result in the register the cycle after acceptance.
// A good start copies positions lo..hi, then runs the fill, cost and drain passes, then gives n results,
// one per cycle while out_ready holds; the single weight memory read port sets the cost pass.
// Sync reset: in_ready low, sequencer idle, vertex_count 32, output empty; tour/weight data stay.
module order_crossover_with_tour_cost_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic [ocx_pkg::VCOUNT_W-1:0]     cfg_write_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [ocx_pkg::IDX_W-1:0]        row,
  input  logic [ocx_pkg::IDX_W-1:0]        column,
  input  logic [ocx_pkg::WFIELD_W-1:0]     weight,
  input  logic [ocx_pkg::IDX_W-1:0]        position,
  input  logic [ocx_pkg::VTX_W-1:0]        vertex,
  input  logic [ocx_pkg::IDX_W-1:0]        cut_first,
  input  logic [ocx_pkg::IDX_W-1:0]        cut_second,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ocx_pkg::IDX_W-1:0]        child_position,
  output logic [ocx_pkg::VTX_W-1:0]        child_vertex,
  output logic [ocx_pkg::COST_W-1:0]       tour_cost,
  output logic                             error,
  output logic                             last
);
  import ocx_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count;
  logic [CNT_W-1:0]    n;
  request_t            req;
  result_t             res;
  logic                res_valid;
  logic                out_free;
  cost_cmd_t           cmd;
  cost_stat_t          stat;
  result_t             out_res;

  // vertex count register; tours use min(vertex_count, MAX_VERTICES)
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_write_enable) begin
      vertex_count <= cfg_write_data;
    end
  end

  assign n = (int'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);

  assign req.operation  = operation;
  assign req.row        = row;
  assign req.column     = column;
  assign req.weight     = weight;
  assign req.position   = position;
  assign req.vertex     = vertex;
  assign req.cut_first  = cut_first;
  assign req.cut_second = cut_second;

  ocx_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req       (req),
    .n         (n),
    .res_valid (res_valid),
    .res_ready (out_free),
    .res       (res),
    .cmd       (cmd),
    .stat      (stat)
  );

  ocx_cost u_cost (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // output register: the sequencer only hands over a result when this slot frees up
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign child_position = out_res.position;
  assign child_vertex   = out_res.vertex;
  assign tour_cost      = out_res.cost;
  assign error          = out_res.error;
  assign last           = out_res.last;

endmodule
